// ===== rtl/utf8s_pkg.sv =====
// Shared constants, types and byte classification for the UTF-8 sanitizer.
`timescale 1ns / 1ps
`default_nettype none

package utf8s_pkg;

  // Most result bytes that one input item can release.
  localparam int unsigned MaxGroup = 4;
  localparam int unsigned GroupCntW = 3;
  // Lead plus continuation bytes held while a sequence is open.
  localparam int unsigned HeldDepth = 3;
  // Default depth of the result buffer, a power of two of at least MaxGroup.
  localparam int unsigned OutbufDepth = 8;

  localparam logic [7:0] QMark = 8'h3F;
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag = 8'h80;
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;

  // Bytes released by one item, in order, with their number.
  typedef struct packed {
    logic [MaxGroup-1:0][7:0] bytes;
    logic [GroupCntW-1:0]     count;
    logic                     fin;
  } group_t;

  // One buffered result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } entry_t;

  // Number of continuation bytes a lead byte opens, zero for anything else.
  function automatic logic [1:0] cont_needed(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) begin
      n = 2'd1;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      n = 2'd2;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8s_in_if.sv =====
// Input channel: one raw byte per item with its end-of-text flag.
`timescale 1ns / 1ps
`default_nettype none

interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8s_out_if.sv =====
// Output channel: one sanitized byte per item with its run and text flags.
`timescale 1ns / 1ps
`default_nettype none

interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output run_last, output text_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input text_end,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8s_step.sv =====
// Input register and sequence decoder that turns one byte into a group of results.
`timescale 1ns / 1ps
`default_nettype none

module utf8s_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  utf8s_in_if.sink               in_i,
  input  wire logic              room_i,
  output utf8s_pkg::group_t      group_o,
  output logic                   group_valid_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;
  logic       take;

  logic [utf8s_pkg::HeldDepth-1:0][7:0] held_q, held_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] need_q, need_d;

  logic       is_cont;
  logic       fresh;
  logic       as_qmark;
  logic [1:0] pre_n;
  logic       tail_v;
  logic [7:0] tail_b;
  logic [1:0] extra;

  // The decoder consumes the registered byte once the buffer has room for a full group.
  assign take = in_valid_q && room_i;
  assign in_i.ready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
      in_fin_q  <= in_i.is_final;
    end
  end

  always_comb begin
    held_d   = held_q;
    cnt_d    = cnt_q;
    need_d   = need_q;
    is_cont  = (in_byte_q & utf8s_pkg::ContMask) == utf8s_pkg::ContTag;
    extra    = utf8s_pkg::cont_needed(in_byte_q);
    fresh    = 1'b1;
    as_qmark = 1'b0;
    pre_n    = 2'd0;
    tail_v   = 1'b0;
    tail_b   = in_byte_q;

    if (need_q != 2'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (need_q == 2'd1) begin
          // Sequence complete: release the held bytes and this one unchanged.
          pre_n  = cnt_q;
          tail_v = 1'b1;
          cnt_d  = 2'd0;
          need_d = 2'd0;
        end else if (in_fin_q) begin
          // Text ends inside the sequence.
          pre_n    = cnt_q;
          as_qmark = 1'b1;
          tail_v   = 1'b1;
          tail_b   = utf8s_pkg::QMark;
          cnt_d    = 2'd0;
          need_d   = 2'd0;
        end else begin
          if (cnt_q < 2'(utf8s_pkg::HeldDepth)) begin
            held_d[cnt_q] = in_byte_q;
            cnt_d         = cnt_q + 2'd1;
          end
          need_d = need_q - 2'd1;
        end
      end else begin
        // Broken sequence: flush as replacements, then treat the byte afresh.
        pre_n    = cnt_q;
        as_qmark = 1'b1;
        cnt_d    = 2'd0;
        need_d   = 2'd0;
      end
    end

    if (fresh) begin
      if (in_byte_q < utf8s_pkg::AsciiLimit) begin
        tail_v = 1'b1;
      end else if (extra == 2'd0 || in_fin_q) begin
        tail_v = 1'b1;
        tail_b = utf8s_pkg::QMark;
      end else begin
        held_d[0] = in_byte_q;
        cnt_d     = 2'd1;
        need_d    = extra;
      end
    end
  end

  always_comb begin
    group_o.bytes = '0;
    for (int i = 0; i < utf8s_pkg::HeldDepth; i++) begin
      if (2'(i) < pre_n) begin
        group_o.bytes[i] = as_qmark ? utf8s_pkg::QMark : held_q[i];
      end
    end
    if (tail_v) begin
      group_o.bytes[pre_n] = tail_b;
    end
    group_o.count = utf8s_pkg::GroupCntW'(pre_n) + utf8s_pkg::GroupCntW'(tail_v);
    group_o.fin   = in_fin_q;
  end

  assign group_valid_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      need_q <= 2'd0;
    end else if (take) begin
      cnt_q  <= cnt_d;
      need_q <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8s_outbuf.sv =====
// Result buffer that takes a group of up to four bytes and hands out one per item.
`timescale 1ns / 1ps
`default_nettype none

module utf8s_outbuf #(
  parameter int unsigned Depth = utf8s_pkg::OutbufDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_valid_i,
  input  wire utf8s_pkg::group_t group_i,
  output logic                   room_o,
  utf8s_out_if.source            out_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  utf8s_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [utf8s_pkg::GroupCntW-1:0] wr_n;
  logic            pop;

  assign wr_n   = wr_valid_i ? group_i.count : '0;
  assign pop    = out_o.valid && out_o.ready;
  assign room_o = count_q <= CntW'(Depth - utf8s_pkg::MaxGroup);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < utf8s_pkg::MaxGroup; i++) begin
      if (utf8s_pkg::GroupCntW'(i) < wr_n) begin
        mem_q[wr_ptr_q + PtrW'(i)].out_byte <= group_i.bytes[i];
        mem_q[wr_ptr_q + PtrW'(i)].run_last <=
          (utf8s_pkg::GroupCntW'(i) + 1'b1) == group_i.count;
        mem_q[wr_ptr_q + PtrW'(i)].text_end <=
          ((utf8s_pkg::GroupCntW'(i) + 1'b1) == group_i.count) && group_i.fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(wr_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(wr_n) - CntW'(pop);
    end
  end

  assign out_o.valid    = count_q != '0;
  assign out_o.out_byte = mem_q[rd_ptr_q].out_byte;
  assign out_o.run_last = mem_q[rd_ptr_q].run_last;
  assign out_o.text_end = mem_q[rd_ptr_q].text_end;

endmodule

`default_nettype wire

// ===== rtl/utf8_sanitizer_unit.sv =====
// Top level of the UTF-8 sanitizer: byte decoder followed by a result buffer.
//
//   Channel     Direction  Payload                          Handshake
//   byte_in_i   in         in_byte[7:0], is_final           valid / ready
//   byte_out_o  out        out_byte[7:0], run_last, text_end valid / ready
//
// One input byte is accepted per cycle while the buffer has room.  It lands
// in an input register, is decoded from there, and its results are written
// into the buffer, from which the output channel offers them in order.
// Bytes of an open sequence are held in the decoder and released together
// when the sequence completes, breaks or the text ends; that group of up to
// four results is written into the buffer at once.
// The decoder takes a byte only while the buffer has room for a full group,
// which throttles the input when the output side stalls; since each byte
// yields one result overall, the rate without stalls is one item per cycle.
// Reset is asynchronous and active low; it empties the buffer and closes any
// open sequence.
`timescale 1ns / 1ps
`default_nettype none

module utf8_sanitizer_unit #(
  // Result buffer entries; a power of two of at least four.
  parameter int unsigned OutbufDepth = utf8s_pkg::OutbufDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  utf8s_in_if.sink    byte_in_i,
  utf8s_out_if.source byte_out_o
);

  utf8s_pkg::group_t group;
  logic              group_valid;
  logic              room;

  // Decoder: holds the sequence state and turns each byte into a result group.
  utf8s_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (byte_in_i),
    .room_i        (room),
    .group_o       (group),
    .group_valid_o (group_valid)
  );

  // Buffer: serializes each group onto the output channel, one byte per item.
  utf8s_outbuf #(
    .Depth (OutbufDepth)
  ) u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (group_valid),
    .group_i    (group),
    .room_o     (room),
    .out_o      (byte_out_o)
  );

endmodule

`default_nettype wire

// ===== dv/utf8_stream_checker.sv =====
// Result checker for the UTF-8 sanitizer: predicts every output byte and compares it.
`timescale 1ns / 1ps

module utf8_stream_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_final_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic       out_run_last_i,
  input  wire logic       out_text_end_i,
  output int unsigned     mismatches_o,
  output int unsigned     pending_o
);

  utf8s_pkg::entry_t expected_q[$];
  utf8s_pkg::entry_t want;
  logic [7:0] held_bytes_q[utf8s_pkg::HeldDepth];
  logic [1:0] held_n_q;
  logic [1:0] owed_n_q;

  // Continuation bytes that a lead byte asks for; zero for anything that is no lead.
  function automatic logic [1:0] tail_len(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b >= utf8s_pkg::Lead4Lo && b <= utf8s_pkg::Lead4Hi) begin
      n = 2'd3;
    end else if (b >= utf8s_pkg::Lead3Lo && b <= utf8s_pkg::Lead3Hi) begin
      n = 2'd2;
    end else if (b >= utf8s_pkg::Lead2Lo && b <= utf8s_pkg::Lead2Hi) begin
      n = 2'd1;
    end
    return n;
  endfunction

  // Advances the decoder state by one input byte and queues the bytes it releases.
  function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
    logic [7:0]        group_q[$];
    logic              fresh;
    logic [1:0]        tail;
    utf8s_pkg::entry_t e;
    int                i;
    fresh = 1'b1;
    if (owed_n_q != 2'd0) begin
      if ((b & utf8s_pkg::ContMask) == utf8s_pkg::ContTag) begin
        fresh = 1'b0;
        if (owed_n_q == 2'd1) begin
          for (i = 0; i < held_n_q; i++) group_q.insert(group_q.size(), held_bytes_q[i]);
          group_q.insert(group_q.size(), b);
          held_n_q = 2'd0;
          owed_n_q = 2'd0;
        end else if (fin) begin
          for (i = 0; i <= held_n_q; i++) group_q.insert(group_q.size(), utf8s_pkg::QMark);
          held_n_q = 2'd0;
          owed_n_q = 2'd0;
        end else begin
          if (held_n_q < utf8s_pkg::HeldDepth) begin
            held_bytes_q[held_n_q] = b;
            held_n_q++;
          end
          owed_n_q--;
        end
      end else begin
        // The sequence is broken, so every held byte turns into a question mark.
        for (i = 0; i < held_n_q; i++) group_q.insert(group_q.size(), utf8s_pkg::QMark);
        held_n_q = 2'd0;
        owed_n_q = 2'd0;
      end
    end
    if (fresh) begin
      tail = tail_len(b);
      if (b < utf8s_pkg::AsciiLimit) begin
        group_q.insert(group_q.size(), b);
      end else if (tail == 2'd0 || fin) begin
        group_q.insert(group_q.size(), utf8s_pkg::QMark);
      end else begin
        held_bytes_q[0] = b;
        held_n_q = 2'd1;
        owed_n_q = tail;
      end
    end
    for (i = 0; i < group_q.size(); i++) begin
      e.out_byte = group_q[i];
      e.run_last = (i == group_q.size() - 1);
      e.text_end = e.run_last && fin;
      expected_q.insert(expected_q.size(), e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      held_n_q = 2'd0;
      owed_n_q = 2'd0;
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got byte %h run_last %b text_end %b",
                   $time, out_byte_i, out_run_last_i, out_text_end_i);
          mismatches_o++;
        end else begin
          want = expected_q.pop_front();
          if (want.out_byte !== out_byte_i) begin
            $display("%0t: out_byte expected %h got %h", $time, want.out_byte, out_byte_i);
            mismatches_o++;
          end
          if (want.run_last !== out_run_last_i) begin
            $display("%0t: run_last expected %b got %b", $time, want.run_last, out_run_last_i);
            mismatches_o++;
          end
          if (want.text_end !== out_text_end_i) begin
            $display("%0t: text_end expected %b got %b", $time, want.text_end, out_text_end_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        sanitize_byte(in_byte_i, in_final_i);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== dv/utf8_sanitizer_unit_test.sv =====
// Top of the UTF-8 sanitizer testbench: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

// The sanitizer sits beside a checker that watches both channels. This module only
// builds texts, pushes them in one item per byte, paces the result side and decides
// the outcome from the checker's mismatch and pending counts.
module utf8_sanitizer_unit_test;

  // A run stuck this many cycles without any handshake is treated as hung. The
  // longest correct quiet stretch is the long receiver hold below plus a sender gap.
  localparam int unsigned IdleLimit = 2000;
  // Cycles the receiver refuses results during the deliberate back-pressure phase.
  localparam int unsigned HoldCycles = 250;
  // Cycles to keep watching after the last expected result, to catch strays.
  localparam int unsigned TailCycles = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  utf8s_in_if  byte_in ();
  utf8s_out_if byte_out ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent_count;
  logic [7:0]  text_q[$];

  // Pacing controls for the sender and the result side.
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  logic rx_hold_req = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  utf8_sanitizer_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_in_i  (byte_in),
    .byte_out_o (byte_out)
  );

  utf8_stream_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (byte_in.valid),
    .in_ready_i     (byte_in.ready),
    .in_byte_i      (byte_in.in_byte),
    .in_final_i     (byte_in.is_final),
    .out_valid_i    (byte_out.valid),
    .out_ready_i    (byte_out.ready),
    .out_byte_i     (byte_out.out_byte),
    .out_run_last_i (byte_out.run_last),
    .out_text_end_i (byte_out.text_end),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Idle lengths: mostly none, often short, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A lead byte for a sequence with the given number of continuation bytes.
  function automatic logic [7:0] pick_lead(input int unsigned tail);
    if (tail == 1) return 8'($urandom_range(utf8s_pkg::Lead2Lo, utf8s_pkg::Lead2Hi));
    if (tail == 2) return 8'($urandom_range(utf8s_pkg::Lead3Lo, utf8s_pkg::Lead3Hi));
    return 8'($urandom_range(utf8s_pkg::Lead4Lo, utf8s_pkg::Lead4Hi));
  endfunction

  // Builds one random text. Most pieces are ASCII or complete multi-byte characters
  // with random payload bits, so the decoder spends its time inside open sequences.
  // The rest are cut-short sequences, mostly broken by the next piece, and raw noise.
  // Some texts also lose their last byte, so that they may end inside a sequence.
  function automatic void build_text();
    int unsigned pieces, kind, tail, k, kept;
    text_q.delete();
    pieces = $urandom_range(1, 8);
    for (k = 0; k < pieces; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        text_q.insert(text_q.size(), 8'($urandom_range(0, 8'h7F)));
      end else if (kind < 90) begin
        tail = $urandom_range(1, 3);
        kept = (kind < 80) ? tail : $urandom_range(0, tail - 1);
        text_q.insert(text_q.size(), pick_lead(tail));
        repeat (kept) begin
          text_q.insert(text_q.size(), utf8s_pkg::ContTag | 8'($urandom_range(0, 63)));
        end
      end else begin
        text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      end
    end
    if (text_q.size() > 1 && $urandom_range(0, 5) == 0) void'(text_q.pop_back());
  endfunction

  // Offers one item from the falling edge on and returns once it has been taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      byte_in.valid <= 1'b0;
    end
    @(negedge clk_i);
    byte_in.valid    <= 1'b1;
    byte_in.in_byte  <= b;
    byte_in.is_final <= fin;
    do @(posedge clk_i); while (!byte_in.ready);
    sent_count++;
  endtask

  // Sends the current text, flagging its last byte as the end of the text.
  task automatic send_text();
    int unsigned i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_random(input int unsigned n);
    int unsigned target;
    target = sent_count + n;
    while (sent_count < target) begin
      build_text();
      send_text();
    end
  endtask

  // Takes the sender off the channel until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    byte_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Result side. It stalls at random, runs without stalls while rx_steady is set,
  // and once on request refuses results for a long stretch so that the buffer
  // fills and the input side backs up.
  initial begin : result_side
    int unsigned stall;
    logic        hold_taken;
    stall = 0;
    hold_taken = 1'b0;
    byte_out.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall = HoldCycles;
      end else if (stall == 0 && !rx_steady && $urandom_range(0, 1) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        byte_out.ready <= 1'b0;
        stall--;
      end else begin
        byte_out.ready <= 1'b1;
      end
    end
  end

  // Any handshake on either side restarts the count.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((byte_in.valid && byte_in.ready) || (byte_out.valid && byte_out.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    byte_in.valid    <= 1'b0;
    byte_in.in_byte  <= 8'h00;
    byte_in.is_final <= 1'b0;
    sent_count = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed text one: the ASCII extremes, a stray continuation, the bad leads
    // at both ends of their ranges, then the shortest and longest valid sequences
    // at their range limits. The text ends right on the byte that completes a
    // four-byte sequence, so all four bytes come out together and the last one
    // carries the end-of-text flag.
    text_q = '{8'h00, 8'h7F, 8'h80, 8'hC0, 8'hC1, 8'hF5, 8'hFF, 8'hC2, 8'h80,
               8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'hBF, 8'hBF, 8'hBF};
    send_text();
    // Directed text two: an ASCII byte breaks an open sequence and is then passed
    // on, and the text ends on a continuation that leaves its sequence incomplete.
    text_q = '{8'hE0, 8'h41, 8'hF0, 8'h80, 8'h80};
    send_text();
    // Directed text three: the text ends on a lead byte.
    text_q = '{8'hDF};
    send_text();

    send_random(50);
    // The sender now waits for every outstanding result before going on.
    wait_drained();

    // Long receiver hold while the sender keeps offering items without gaps.
    tx_steady = 1'b1;
    rx_hold_req = 1'b1;
    send_random(35);

    // A stretch without idling on either side.
    rx_steady = 1'b1;
    send_random(35);

    rx_steady = 1'b0;
    tx_steady = 1'b0;
    send_random(55);

    @(negedge clk_i);
    byte_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/utf8s_pkg.sv
rtl/utf8s_in_if.sv
rtl/utf8s_out_if.sv
rtl/utf8s_step.sv
rtl/utf8s_outbuf.sv
rtl/utf8_sanitizer_unit.sv
dv/utf8_stream_checker.sv
dv/utf8_sanitizer_unit_test.sv
